// ===== design/keyword_lexer_with_positions_top_macros.svh =====
// Assertion macros for the keyword lexer.
`ifndef KEYWORD_LEXER_WITH_POSITIONS_TOP_MACROS_SVH
`define KEYWORD_LEXER_WITH_POSITIONS_TOP_MACROS_SVH

`ifndef SYNTH
`define KWLEX_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kwlex check failed");
`define KWLEX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kwlex check failed");
`else
`define KWLEX_ASSERT_SAME(label, ante, cons)
`define KWLEX_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== design/kwlex_pkg.sv =====
package kwlex_pkg;

  localparam int IDENT_CHARS   = 8;
  localparam int NUMBER_BITS   = 31;
  localparam int POSITION_BITS = 16;
  localparam int TEXT_BITS     = 64;
  localparam int LEN_BITS      = 8;

  typedef enum logic [3:0] {
    KIND_LET    = 4'd0,
    KIND_LAMBDA = 4'd1,
    KIND_IF     = 4'd2,
    KIND_THEN   = 4'd3,
    KIND_ELSE   = 4'd4,
    KIND_DEFINE = 4'd5,
    KIND_IDENT  = 4'd6,
    KIND_NUMBER = 4'd7,
    KIND_LPAR   = 4'd8,
    KIND_RPAR   = 4'd9,
    KIND_EOF    = 4'd10,
    KIND_ERROR  = 4'd11
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_WORD   = 2'd1,
    MODE_DIGITS = 2'd2
  } mode_t;

  typedef struct packed {
    kind_t                     kind;
    logic [NUMBER_BITS-1:0]    number_value;
    logic [TEXT_BITS-1:0]      ident_text;
    logic [LEN_BITS-1:0]       ident_length;
    logic                      overflow;
    logic [POSITION_BITS-1:0]  token_line;
    logic [POSITION_BITS-1:0]  token_column;
    logic                      last;
  } tok_t;

  typedef struct packed {
    logic push0;
    logic push1;
    tok_t tok0;
    tok_t tok1;
  } wr_t;

  typedef struct packed {
    logic room;
  } fifo_sts_t;

endpackage

// ===== design/kwlex_if.sv =====
interface kwlex_in_if;
  import kwlex_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_input;

  modport source (output valid, output character, output end_of_input, input ready);
  modport sink (input valid, input character, input end_of_input, output ready);
endinterface

interface kwlex_out_if;
  import kwlex_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [3:0]               token_kind;
  logic [NUMBER_BITS-1:0]   number_value;
  logic [TEXT_BITS-1:0]     ident_text;
  logic [LEN_BITS-1:0]      ident_length;
  logic                     overflow;
  logic [POSITION_BITS-1:0] token_line;
  logic [POSITION_BITS-1:0] token_column;
  logic                     last;

  modport source (
    output valid, output token_kind, output number_value, output ident_text,
    output ident_length, output overflow, output token_line, output token_column,
    output last, input ready
  );
  modport sink (
    input valid, input token_kind, input number_value, input ident_text,
    input ident_length, input overflow, input token_line, input token_column,
    input last, output ready
  );
endinterface

// ===== design/kwlex_core.sv =====
module kwlex_core
  import kwlex_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_character,
  input  logic       in_end_of_input,
  input  fifo_sts_t  sts,
  output wr_t        wr
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [NUMBER_BITS-1:0]   NUM_MAX = '1;
  localparam int                       SUM_W   = NUMBER_BITS + 4;

  // String literals hold the first character in the top byte, so the words are reversed.
  localparam logic [TEXT_BITS-1:0] TXT_LET    = TEXT_BITS'("tel");
  localparam logic [TEXT_BITS-1:0] TXT_LAMBDA = TEXT_BITS'("adbmal");
  localparam logic [TEXT_BITS-1:0] TXT_IF     = TEXT_BITS'("fi");
  localparam logic [TEXT_BITS-1:0] TXT_THEN   = TEXT_BITS'("neht");
  localparam logic [TEXT_BITS-1:0] TXT_ELSE   = TEXT_BITS'("esle");
  localparam logic [TEXT_BITS-1:0] TXT_DEFINE = TEXT_BITS'("enifed");

  function automatic kind_t word_kind(input logic [TEXT_BITS-1:0] txt,
                                      input logic [LEN_BITS-1:0] cnt);
    kind_t k;
    k = KIND_IDENT;
    if (cnt == LEN_BITS'(3) && txt == TXT_LET) k = KIND_LET;
    if (cnt == LEN_BITS'(6) && txt == TXT_LAMBDA) k = KIND_LAMBDA;
    if (cnt == LEN_BITS'(2) && txt == TXT_IF) k = KIND_IF;
    if (cnt == LEN_BITS'(4) && txt == TXT_THEN) k = KIND_THEN;
    if (cnt == LEN_BITS'(4) && txt == TXT_ELSE) k = KIND_ELSE;
    if (cnt == LEN_BITS'(6) && txt == TXT_DEFINE) k = KIND_DEFINE;
    return k;
  endfunction

  logic                     in_vld_r;
  logic [7:0]               char_r;
  logic                     eoi_r;
  mode_t                    mode_r, mode_nxt;
  logic [TEXT_BITS-1:0]     text_r, text_nxt;
  logic [LEN_BITS-1:0]      cnt_r, cnt_nxt;
  logic [NUMBER_BITS-1:0]   acc_r, acc_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [POSITION_BITS-1:0] line_r, line_nxt, col_r, col_nxt;
  logic [POSITION_BITS-1:0] sline_r, sline_nxt, scol_r, scol_nxt;

  logic                     fire;
  logic                     word, digits, running;
  logic                     is_letter, is_digit, is_space, is_nl;
  logic [POSITION_BITS-1:0] col_inc, line_inc, base_line, base_col;
  logic [3:0]               digit;
  logic [SUM_W-1:0]         acc_ext, sum;
  kind_t                    wkind;
  tok_t                     fin_tok, own_tok;
  logic                     has_own;

  assign fire     = in_vld_r && sts.room;
  assign in_ready = !in_vld_r || fire;

  assign word      = (mode_r == MODE_WORD);
  assign digits    = (mode_r == MODE_DIGITS);
  assign running   = word || digits;
  assign is_letter = (char_r >= "a" && char_r <= "z") || (char_r >= "A" && char_r <= "Z");
  assign is_digit  = (char_r >= "0" && char_r <= "9");
  assign is_nl     = (char_r == 8'h0a);
  assign is_space  = (char_r == " ") || (char_r == 8'h09) || is_nl;
  assign col_inc   = (col_r < POS_MAX) ? col_r + POSITION_BITS'(1) : col_r;
  assign line_inc  = (line_r < POS_MAX) ? line_r + POSITION_BITS'(1) : line_r;
  assign base_line = running ? line_r : sline_r;
  assign base_col  = running ? col_r : scol_r;
  assign digit     = 4'(char_r - "0");
  assign acc_ext   = SUM_W'(acc_r);
  assign sum       = (acc_ext << 3) + (acc_ext << 1) + SUM_W'(digit);
  assign wkind     = word_kind(text_r, cnt_r);

  always_comb begin
    fin_tok              = '0;
    fin_tok.kind         = word ? wkind : KIND_NUMBER;
    fin_tok.token_line   = sline_r;
    fin_tok.token_column = scol_r;
    if (word && wkind == KIND_IDENT) begin
      fin_tok.ident_text   = text_r;
      fin_tok.ident_length = cnt_r;
      fin_tok.overflow     = ovf_r;
    end else if (digits) begin
      fin_tok.number_value = acc_r;
      fin_tok.overflow     = ovf_r;
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    text_nxt  = text_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    sline_nxt = sline_r;
    scol_nxt  = scol_r;
    own_tok   = '0;
    has_own   = 1'b0;
    own_tok.token_line   = base_line;
    own_tok.token_column = base_col;
    own_tok.kind         = KIND_ERROR;
    if (fire) begin
      if (eoi_r) begin
        mode_nxt  = MODE_IDLE;
        text_nxt  = '0;
        cnt_nxt   = '0;
        acc_nxt   = '0;
        ovf_nxt   = 1'b0;
        col_nxt   = col_inc;
        has_own   = 1'b1;
        own_tok.kind = KIND_EOF;
        sline_nxt = line_r;
        scol_nxt  = col_inc;
      end else if (word && is_letter) begin
        for (int i = 0; i < IDENT_CHARS; i++) begin
          if (cnt_r == LEN_BITS'(i)) text_nxt[8*i +: 8] = char_r;
        end
        if (cnt_r >= LEN_BITS'(IDENT_CHARS)) ovf_nxt = 1'b1;
        if (cnt_r != '1) cnt_nxt = cnt_r + LEN_BITS'(1);
        col_nxt = col_inc;
      end else if (digits && is_digit) begin
        if (sum > SUM_W'(NUM_MAX)) begin
          acc_nxt = NUM_MAX;
          ovf_nxt = 1'b1;
        end else begin
          acc_nxt = sum[NUMBER_BITS-1:0];
        end
        col_nxt = col_inc;
      end else begin
        mode_nxt  = MODE_IDLE;
        text_nxt  = '0;
        cnt_nxt   = '0;
        acc_nxt   = '0;
        ovf_nxt   = 1'b0;
        col_nxt   = is_nl ? POSITION_BITS'(1) : col_inc;
        line_nxt  = is_nl ? line_inc : line_r;
        sline_nxt = base_line;
        scol_nxt  = base_col;
        if (is_space) begin
          has_own = 1'b0;
        end else if (is_letter) begin
          mode_nxt = MODE_WORD;
          text_nxt = TEXT_BITS'(char_r);
          cnt_nxt  = LEN_BITS'(1);
        end else if (is_digit) begin
          mode_nxt = MODE_DIGITS;
          acc_nxt  = NUMBER_BITS'(digit);
        end else begin
          has_own = 1'b1;
          if (char_r == "(") own_tok.kind = KIND_LPAR;
          else if (char_r == ")") own_tok.kind = KIND_RPAR;
          else own_tok.kind = KIND_ERROR;
          sline_nxt = is_nl ? line_inc : line_r;
          scol_nxt  = col_inc;
        end
      end
    end
  end

  logic run_end;
  assign run_end = fire && running && (eoi_r || !((word && is_letter) || (digits && is_digit)));

  always_comb begin
    wr       = '0;
    if (run_end) begin
      wr.push0     = 1'b1;
      wr.tok0      = fin_tok;
      wr.tok0.last = !has_own;
      wr.push1     = has_own;
      wr.tok1      = own_tok;
      wr.tok1.last = 1'b1;
    end else if (fire && has_own) begin
      wr.push0     = 1'b1;
      wr.tok0      = own_tok;
      wr.tok0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      mode_r   <= MODE_IDLE;
      text_r   <= '0;
      cnt_r    <= '0;
      acc_r    <= '0;
      ovf_r    <= 1'b0;
      line_r   <= POSITION_BITS'(1);
      col_r    <= POSITION_BITS'(1);
      sline_r  <= POSITION_BITS'(1);
      scol_r   <= POSITION_BITS'(1);
    end else begin
      if (in_ready) in_vld_r <= in_valid;
      mode_r  <= mode_nxt;
      text_r  <= text_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      sline_r <= sline_nxt;
      scol_r  <= scol_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      char_r <= in_character;
      eoi_r  <= in_end_of_input;
    end
  end

endmodule

// ===== design/kwlex_fifo.sv =====
module kwlex_fifo
  import kwlex_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  wr_t       wr,
  input  logic      pop,
  output fifo_sts_t sts,
  output logic      head_vld,
  output tok_t      head
);

  tok_t       ent_r [4];
  logic [1:0] wptr_r, rptr_r;
  logic [2:0] cnt_r, cnt_nxt;

  assign head_vld = (cnt_r != 3'd0);
  assign head     = ent_r[rptr_r];
  assign sts.room = (cnt_r <= 3'd2);
  assign cnt_nxt  = cnt_r + 3'(wr.push0) + 3'(wr.push1) - 3'(pop && head_vld);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_r + 2'(wr.push0) + 2'(wr.push1);
      if (pop && head_vld) rptr_r <= rptr_r + 2'd1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.push0) ent_r[wptr_r] <= wr.tok0;
    if (wr.push1) ent_r[wptr_r + 2'd1] <= wr.tok1;
  end

endmodule

// ===== design/keyword_lexer_with_positions_top.sv =====
// Streaming keyword lexer: one character or end-of-input mark is taken per request, and
// every request can follow the previous one in the next cycle. An accepted request is
// held in the input register until the result queue has room, and is then scanned; its
// tokens are written into the result queue at the end of the scan cycle and from there
// are shown on the result channel in order. Requests that yield at most one token
// sustain one request per cycle while the result side takes a token every cycle; a
// character or end-of-input mark that closes a pending word or number and also gives a
// token of its own yields two tokens, which leave one per cycle through a four-entry
// result queue, and a waiting request stalls while that queue has fewer than two free
// entries.
`include "keyword_lexer_with_positions_top_macros.svh"

module keyword_lexer_with_positions_top
  import kwlex_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  kwlex_in_if.sink  in_ch,
  kwlex_out_if.source out_ch
);

  wr_t       wr;
  fifo_sts_t sts;
  tok_t      head;
  logic      head_vld;

  kwlex_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_character    (in_ch.character),
    .in_end_of_input (in_ch.end_of_input),
    .sts             (sts),
    .wr              (wr)
  );

  kwlex_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .pop      (out_ch.ready),
    .sts      (sts),
    .head_vld (head_vld),
    .head     (head)
  );

  assign out_ch.valid        = head_vld;
  assign out_ch.token_kind   = head.kind;
  assign out_ch.number_value = head.number_value;
  assign out_ch.ident_text   = head.ident_text;
  assign out_ch.ident_length = head.ident_length;
  assign out_ch.overflow     = head.overflow;
  assign out_ch.token_line   = head.token_line;
  assign out_ch.token_column = head.token_column;
  assign out_ch.last         = head.last;

  `KWLEX_ASSERT_SAME(a_eof_is_last, out_ch.valid && out_ch.token_kind == KIND_EOF, out_ch.last)
  `KWLEX_ASSERT_SAME(a_pair_in_order, wr.push1, wr.push0 && !wr.tok0.last && wr.tok1.last)
  `KWLEX_ASSERT_SAME(a_pos_nonzero, out_ch.valid,
    out_ch.token_line != '0 && out_ch.token_column != '0)
  `KWLEX_ASSERT_NEXT(a_held_when_stalled, out_ch.valid && !out_ch.ready,
    out_ch.valid && $stable(out_ch.token_kind))

endmodule

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kwlex_pkg::*;

  localparam longint unsigned VALUE_MAX = (64'd1 << NUMBER_BITS) - 1;
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  class token_scoreboard;
    string keyword_names[6] = '{"let", "lambda", "if", "then", "else", "define"};
    tok_t expected_tokens[$];
    int unsigned failures;
    mode_t mode;
    logic [TEXT_BITS-1:0] text;
    logic [LEN_BITS-1:0] text_len;
    logic [NUMBER_BITS-1:0] value;
    logic overflow_seen;
    logic [POSITION_BITS-1:0] line_no;
    logic [POSITION_BITS-1:0] col_no;
    logic [POSITION_BITS-1:0] start_line;
    logic [POSITION_BITS-1:0] start_col;

    function new();
      failures = 0;
      mode = MODE_IDLE;
      clear_run();
      line_no = POSITION_BITS'(1);
      col_no = POSITION_BITS'(1);
      start_line = POSITION_BITS'(1);
      start_col = POSITION_BITS'(1);
    endfunction

    function int unsigned pending();
      return expected_tokens.size();
    endfunction

    function void clear_run();
      text = '0;
      text_len = '0;
      value = '0;
      overflow_seen = 1'b0;
    endfunction

    function void mark_start();
      start_line = line_no;
      start_col = col_no;
    endfunction

    function void emit(kind_t k, logic [NUMBER_BITS-1:0] num, logic [TEXT_BITS-1:0] txt,
                       logic [LEN_BITS-1:0] len, logic ovf);
      tok_t t;
      t.kind = k;
      t.number_value = num;
      t.ident_text = txt;
      t.ident_length = len;
      t.overflow = ovf;
      t.token_line = start_line;
      t.token_column = start_col;
      t.last = 1'b0;
      expected_tokens.insert(expected_tokens.size(), t);
    endfunction

    function void count_char(bit is_newline);
      if (col_no != POS_MAX) col_no++;
      if (is_newline) begin
        if (line_no != POS_MAX) line_no++;
        col_no = POSITION_BITS'(1);
      end
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function kind_t word_kind();
      logic [TEXT_BITS-1:0] packed_name;
      for (int i = 0; i < 6; i++) begin
        packed_name = '0;
        for (int j = 0; j < keyword_names[i].len(); j++)
          packed_name[8*j +: 8] = keyword_names[i][j];
        if (keyword_names[i].len() == text_len && packed_name == text) return kind_t'(i);
      end
      return KIND_IDENT;
    endfunction

    function void finish_run();
      kind_t k;
      if (mode == MODE_WORD) begin
        k = word_kind();
        if (k == KIND_IDENT) emit(k, '0, text, text_len, overflow_seen);
        else emit(k, '0, '0, '0, 1'b0);
      end else begin
        emit(KIND_NUMBER, value, '0, '0, overflow_seen);
      end
      mode = MODE_IDLE;
      clear_run();
      mark_start();
    endfunction

    function void add_letter(logic [7:0] c);
      if (text_len < IDENT_CHARS) text[8*text_len +: 8] = c;
      else overflow_seen = 1'b1;
      if (text_len != 8'hFF) text_len++;
    endfunction

    function void add_digit(logic [7:0] c);
      longint unsigned d;
      d = 64'(c - "0");
      if (value > (VALUE_MAX - d) / 10) begin
        value = NUMBER_BITS'(VALUE_MAX);
        overflow_seen = 1'b1;
      end else begin
        value = NUMBER_BITS'(value * 10 + d);
      end
    endfunction

    function void note_request(logic [7:0] c, bit eoi);
      int unsigned already;
      already = expected_tokens.size();
      if (eoi) begin
        if (mode != MODE_IDLE) finish_run();
        count_char(1'b0);
        emit(KIND_EOF, '0, '0, '0, 1'b0);
        mark_start();
      end else if (mode == MODE_WORD && is_letter(c)) begin
        add_letter(c);
        count_char(1'b0);
      end else if (mode == MODE_DIGITS && is_digit(c)) begin
        add_digit(c);
        count_char(1'b0);
      end else begin
        if (mode != MODE_IDLE) finish_run();
        count_char(c == "\n");
        if (is_letter(c)) begin
          mode = MODE_WORD;
          add_letter(c);
        end else if (is_digit(c)) begin
          mode = MODE_DIGITS;
          add_digit(c);
        end else if (!(c == " " || c == "\t" || c == "\n")) begin
          case (c)
            "(": emit(KIND_LPAR, '0, '0, '0, 1'b0);
            ")": emit(KIND_RPAR, '0, '0, '0, 1'b0);
            default: emit(KIND_ERROR, '0, '0, '0, 1'b0);
          endcase
          mark_start();
        end
      end
      if (expected_tokens.size() > already)
        expected_tokens[expected_tokens.size()-1].last = 1'b1;
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_token(tok_t got);
      tok_t want;
      if (expected_tokens.size() == 0) begin
        $error("token of kind %0d arrived with none expected", got.kind);
        failures++;
        return;
      end
      want = expected_tokens.pop_front();
      compare_field("token_kind", want.kind, got.kind);
      compare_field("number_value", want.number_value, got.number_value);
      compare_field("ident_text", want.ident_text, got.ident_text);
      compare_field("ident_length", want.ident_length, got.ident_length);
      compare_field("overflow", want.overflow, got.overflow);
      compare_field("token_line", want.token_line, got.token_line);
      compare_field("token_column", want.token_column, got.token_column);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit steady;
  int unsigned requests_sent;
  token_scoreboard sb = new();

  kwlex_in_if in_ch();
  kwlex_out_if out_ch();

  keyword_lexer_with_positions_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= 26);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_token(tok_t'({out_ch.token_kind, out_ch.number_value, out_ch.ident_text,
                             out_ch.ident_length, out_ch.overflow, out_ch.token_line,
                             out_ch.token_column, out_ch.last}));
  end

  function automatic logic [7:0] random_letter();
    logic [7:0] base;
    base = $urandom_range(0, 1) ? "a" : "A";
    return base + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] random_blank();
    case ($urandom_range(0, 2))
      0: return " ";
      1: return "\t";
      default: return "\n";
    endcase
  endfunction

  task automatic send_request(logic [7:0] c, bit eoi);
    while (!steady && $urandom_range(0, 99) < 26) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.character <= c;
    in_ch.end_of_input <= eoi;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(c, eoi);
    requests_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned random_start;
    int pick;
    in_ch.valid = 1'b0;
    in_ch.character = 8'h00;
    in_ch.end_of_input = 1'b0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    steady = 1'b0;
    requests_sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_text("let lambda if then else define\t");
    send_text("abcdefghij(");
    send_text("ZyXwVu 4294967296)");
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
    send_text("12");
    send_request(8'hFF, 1'b1);
    send_text("q");
    send_request(8'h00, 1'b1);
    send_request(8'hA5, 1'b1);
    send_text("0 2147483647 2147483648\n");

    // Hold the input until the lexer has delivered every outstanding token.
    wait_drained();

    steady = 1'b1;
    send_text("x(\n");

    random_start = requests_sent;
    while (requests_sent < random_start + 540) begin
      steady = (requests_sent - random_start) < 120;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        send_text(sb.keyword_names[$urandom_range(0, 5)]);
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 3))
            0: send_request("(", 1'b0);
            1: send_request(")", 1'b0);
            default: send_request(random_blank(), 1'b0);
          endcase
        end
      end else if (pick < 40) begin
        repeat ($urandom_range(1, 12)) send_request(random_letter(), 1'b0);
      end else if (pick < 56) begin
        repeat ($urandom_range(1, 12)) send_request(8'("0" + $urandom_range(0, 9)), 1'b0);
      end else if (pick < 68) begin
        send_request($urandom_range(0, 1) ? "(" : ")", 1'b0);
      end else if (pick < 84) begin
        send_request(random_blank(), 1'b0);
      end else if (pick < 89) begin
        send_request(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        send_request(8'($urandom_range(0, 255)), 1'b0);
      end
    end

    steady = 1'b1;
    send_text("end 7");
    send_request(8'h3C, 1'b1);
    steady = 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.failures == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
